>>> rtl/core/pll_divider_and_fifo_timing_calc_assert.svh
// Assertion macros for the clock divider / FIFO timing block.
// Used by modules that clock their checks on clk and reset on rst_n.
`ifndef PLL_DIVIDER_AND_FIFO_TIMING_CALC_ASSERT_SVH
`define PLL_DIVIDER_AND_FIFO_TIMING_CALC_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PDFT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdft check failed");

// antecedent implies consequent in the next cycle
`define PDFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdft check failed");

`endif

>>> rtl/core/pdft_pkg.sv
// Shared types and constants for the clock divider / FIFO timing block.
// No dependencies.
package pdft_pkg;

    localparam int PERIOD_W = 20;
    localparam int BPP_W    = 6;
    localparam int DIVD_W   = 30;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_REFERENCE_PERIOD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PLL_PERIOD       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SDRAM_MEMORY     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MEMORY_OVER_1MB  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FEATURE_MASK     = 3'd5;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MEM_RANGE = 2'd1,
        ST_PIX_RANGE = 2'd2,
        ST_DOT_CLOCK = 2'd3
    } status_t;

    localparam logic [DIVD_W-1:0] Q_MIN = 30'd128;   // 16 * 8
    localparam logic [DIVD_W-1:0] Q_MAX = 30'd2040;  // 255 * 8
    localparam logic [7:0] GEN_BASE  = 8'h84;
    localparam logic [7:0] GEN_SDRAM = 8'h04;
    localparam logic [28:0] FOFF_BIAS = 29'd192;     // 3 << 6
    localparam logic [9:0] PLL_MULT = 10'd510;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [PERIOD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIVD_W-1:0] quotient;
    } div_stat_t;

endpackage

>>> rtl/core/pdft_if.sv
// Valid/ready channel interfaces for request and result words.
// Depends on pdft_pkg for field widths.
interface pdft_req_if;
    logic                          valid;
    logic                          ready;
    logic [pdft_pkg::PERIOD_W-1:0] pixel_period;
    logic [pdft_pkg::BPP_W-1:0]    bits_per_pixel;

    modport source (output valid, pixel_period, bits_per_pixel, input ready);
    modport sink   (input valid, pixel_period, bits_per_pixel, output ready);
endinterface

interface pdft_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  reference_divider;
    logic [7:0]  memory_feedback_divider;
    logic [7:0]  pixel_feedback_divider;
    logic [1:0]  pixel_post_code;
    logic [7:0]  general_control;
    logic [4:0]  extended_control;
    logic [22:0] fifo_config_word;
    logic [26:0] fifo_on_off_word;

    modport source (output valid, status, reference_divider, memory_feedback_divider,
                    pixel_feedback_divider, pixel_post_code, general_control,
                    extended_control, fifo_config_word, fifo_on_off_word,
                    input ready);
    modport sink   (input valid, status, reference_divider, memory_feedback_divider,
                    pixel_feedback_divider, pixel_post_code, general_control,
                    extended_control, fifo_config_word, fifo_on_off_word,
                    output ready);
endinterface

>>> rtl/core/pdft_div.sv
// Shared radix-4 restoring divider, two quotient bits per cycle.
// Depends on pdft_pkg. Divide by zero gives an all-ones quotient.
module pdft_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pdft_pkg::div_req_t  req,
    output pdft_pkg::div_stat_t stat
);
    import pdft_pkg::*;

    localparam int STEPS = DIVD_W / 2;

    logic [DIVD_W-1:0]   dq_reg;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] den_reg;
    logic [3:0]          cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [PERIOD_W:0]   t1, t2;
    logic [PERIOD_W-1:0] r1, r2;
    logic                b1, b2;

    always_comb
    begin
        t1 = {rem_reg, dq_reg[DIVD_W-1]};
        b1 = (t1 >= {1'b0, den_reg});
        r1 = b1 ? PERIOD_W'(t1 - {1'b0, den_reg}) : t1[PERIOD_W-1:0];
        t2 = {r1, dq_reg[DIVD_W-2]};
        b2 = (t2 >= {1'b0, den_reg});
        r2 = b2 ? PERIOD_W'(t2 - {1'b0, den_reg}) : t2[PERIOD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 4'd1;
                if (cnt_reg == 4'(STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            dq_reg  <= req.dividend;
            den_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dq_reg  <= {dq_reg[DIVD_W-3:0], b1, b2};
            rem_reg <= r2;
        end
    end

    assign stat.busy     = busy_reg;
    assign stat.done     = done_reg;
    assign stat.quotient = dq_reg;

endmodule

>>> rtl/core/pll_divider_and_fifo_timing_calc.sv
// Sequence: without the FIFO unit, three divisions on the shared divider plus two steps (S_NUM,
// S_DONE) from accepted request to result valid; with the FIFO unit a fourth division, a
// leading-one count and the S_DEN and S_CALC steps are added.
// Throughput: one word at a time; a new request is taken only when the sequencer
// is back in idle. The result register lets the next request start while it waits.
// Reset: rst_n asynchronous, active low; config, state, valid and status registers are reset.
module pll_divider_and_fifo_timing_calc (
    input  logic                             clk,
    input  logic                             rst_n,
    pdft_req_if.sink                         req,
    pdft_rsp_if.source                       rsp,
    input  logic                             wr_en,
    input  logic [pdft_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [pdft_pkg::PERIOD_W-1:0]    wr_data
);
    import pdft_pkg::*;

    `include "pll_divider_and_fifo_timing_calc_assert.svh"

    typedef enum logic [3:0] {
        S_IDLE, S_DRDIV, S_NUM, S_DMEM, S_DPIX, S_DEN, S_DXPR, S_PREC, S_CALC, S_DONE
    } state_t;

    state_t state_reg;

    logic [PERIOD_W-1:0] ref_per_reg, pll_per_reg, mem_per_reg;
    logic                sdram_reg, over1mb_reg;
    logic [3:0]          feat_reg;

    logic [PERIOD_W-1:0] vper_reg;
    logic [BPP_W-1:0]    bpp_reg;
    logic [7:0]          rdiv_reg, mfb_reg, vfb_reg;
    logic [1:0]          mcode_reg, vcode_reg;
    status_t             status_reg;
    logic [27:0]         xpr_reg;
    logic [21:0]         y_reg;
    logic [4:0]          prec_reg;
    logic [28:0]         fon_reg, foff_reg;
    logic [3:0]          lat_reg;

    logic        out_valid_reg;
    logic [1:0]  o_status_reg;
    logic [7:0]  o_rdiv_reg, o_mfb_reg, o_vfb_reg, o_gen_reg;
    logic [1:0]  o_vcode_reg;
    logic [4:0]  o_ext_reg;
    logic [22:0] o_cfg_reg;
    logic [26:0] o_onoff_reg;

    div_req_t  dreq;
    div_stat_t dstat;

    pdft_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .stat (dstat)
    );

    logic              accept;
    logic [DIVD_W-1:0] q;
    logic              q_ok;
    logic [1:0]        q_code;
    logic [7:0]        q_fb;
    logic [27:0]       ref_prod;
    logic [DIVD_W-1:0] fb_num;
    logic [28:0]       pll_prod;
    logic [27:0]       xpr_num;
    logic [13:0]       vb_prod;
    logic [16:0]       den;
    logic [27:0]       xpr_q;
    logic [31:0]       xpr24;
    logic [21:0]       y_init;
    logic [32:0]       xpr_m;
    logic [28:0]       foff_c;
    logic [3:0]        page, lat;
    logic [28:0]       fon_c;
    logic              out_free;
    logic [28:0]       fon_sh, foff_sh;
    logic [27:0]       xpr_sh;
    logic [7:0]        gen_c;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        q    = dstat.quotient;
        q_ok = (q >= Q_MIN) && (q <= Q_MAX);
        if (q < 30'd256)
            q_code = 2'd3;
        else if (q < 30'd512)
            q_code = 2'd2;
        else if (q < 30'd1024)
            q_code = 2'd1;
        else
            q_code = 2'd0;
        // fb = q * post / 8, post = 1 << code
        q_fb = 8'(q >> (~q_code));

        ref_prod = ref_per_reg * rdiv_reg;
        fb_num   = {ref_prod, 2'b00};
        pll_prod = pll_per_reg * PLL_MULT;
        // mfb * vpost * 2^17, vpost = 1 << vcode
        xpr_num  = {mfb_reg, 20'd0} >> (~vcode_reg);
        vb_prod  = vfb_reg * bpp_reg;
        den      = {3'd0, vb_prod} << mcode_reg;

        dreq = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                dreq.start    = accept;
                dreq.dividend = {1'b0, pll_prod};
                dreq.divisor  = ref_per_reg;
            end
            S_NUM:
            begin
                dreq.start    = 1'b1;
                dreq.dividend = fb_num;
                dreq.divisor  = mem_per_reg;
            end
            S_DMEM:
            begin
                dreq.start    = dstat.done && q_ok;
                dreq.dividend = fb_num;
                dreq.divisor  = vper_reg;
            end
            S_DEN:
            begin
                dreq.start    = (bpp_reg != '0);
                dreq.dividend = {2'b00, xpr_num};
                dreq.divisor  = {3'd0, den};
            end
            default:
            begin
                dreq = '0;
            end
        endcase
    end

    always_comb
    begin
        xpr_q  = q[27:0];
        xpr24  = {xpr_q, 4'd0} + {1'b0, xpr_q, 3'd0};
        y_init = feat_reg[0] ? {1'b0, xpr24[31:11]} : xpr_q[27:6];

        xpr_m  = feat_reg[0] ? {1'b0, xpr24} - {5'd0, xpr_reg}
                             : {xpr_reg, 5'd0} - {5'd0, xpr_reg};
        foff_c = {1'b0, xpr_m[32:5]} + FOFF_BIAS;

        if (over1mb_reg)
        begin
            lat  = sdram_reg ? 4'd8 : 4'd6;
            page = sdram_reg ? 4'd8 : 4'd9;
        end
        else
        begin
            lat  = sdram_reg ? 4'd9 : 4'd8;
            page = 4'd10;
        end
        if (xpr_reg >= {13'd0, page, 11'd0} )
            fon_c = {18'd0, ({page, 1'b1} ), 6'd0} + {6'd0, xpr_reg[27:5]};
        else
            fon_c = {17'd0, (6'({page, 1'b0}) + 6'(page) + 6'd2), 6'd0};

        out_free = !out_valid_reg || rsp.ready;
        fon_sh   = fon_reg >> prec_reg;
        foff_sh  = foff_reg >> prec_reg;
        xpr_sh   = xpr_reg >> prec_reg;
        gen_c    = ((feat_reg[2] && sdram_reg) ? GEN_SDRAM : GEN_BASE) | {2'b00, mcode_reg, 4'd0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_per_reg <= 20'd69841;
            pll_per_reg <= 20'd7200;
            mem_per_reg <= 20'd16667;
            sdram_reg   <= 1'b0;
            over1mb_reg <= 1'b0;
            feat_reg    <= 4'd0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_REFERENCE_PERIOD: ref_per_reg <= wr_data;
                REG_PLL_PERIOD:       pll_per_reg <= wr_data;
                REG_MEMORY_PERIOD:    mem_per_reg <= wr_data;
                REG_SDRAM_MEMORY:     sdram_reg   <= wr_data[0];
                REG_MEMORY_OVER_1MB:  over1mb_reg <= wr_data[0];
                REG_FEATURE_MASK:     feat_reg    <= wr_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        vper_reg   <= req.pixel_period;
                        bpp_reg    <= req.bits_per_pixel;
                        status_reg <= ST_OK;
                        state_reg  <= S_DRDIV;
                    end
                end
                S_DRDIV:
                begin
                    if (dstat.done)
                    begin
                        rdiv_reg  <= q[7:0];
                        state_reg <= S_NUM;
                    end
                end
                S_NUM:
                begin
                    state_reg <= S_DMEM;
                end
                S_DMEM:
                begin
                    if (dstat.done)
                    begin
                        mcode_reg <= q_code;
                        mfb_reg   <= q_fb;
                        if (q_ok)
                            state_reg <= S_DPIX;
                        else
                        begin
                            status_reg <= ST_MEM_RANGE;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_DPIX:
                begin
                    if (dstat.done)
                    begin
                        vcode_reg <= q_code;
                        vfb_reg   <= q_fb;
                        if (!q_ok)
                        begin
                            status_reg <= ST_PIX_RANGE;
                            state_reg  <= S_DONE;
                        end
                        else if (feat_reg[1])
                            state_reg <= S_DEN;
                        else
                            state_reg <= S_DONE;
                    end
                end
                S_DEN:
                begin
                    if (bpp_reg == '0)
                    begin
                        status_reg <= ST_DOT_CLOCK;
                        state_reg  <= S_DONE;
                    end
                    else
                        state_reg <= S_DXPR;
                end
                S_DXPR:
                begin
                    if (dstat.done)
                    begin
                        xpr_reg  <= xpr_q;
                        y_reg    <= y_init;
                        prec_reg <= '0;
                        if (q < 30'd2048)
                        begin
                            status_reg <= ST_DOT_CLOCK;
                            state_reg  <= S_DONE;
                        end
                        else
                            state_reg <= S_PREC;
                    end
                end
                S_PREC:
                begin
                    // bit length of y, one bit per cycle
                    if (y_reg != '0)
                    begin
                        y_reg    <= y_reg >> 1;
                        prec_reg <= prec_reg + 5'd1;
                    end
                    else
                    begin
                        prec_reg  <= prec_reg - 5'd5;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    foff_reg  <= foff_c;
                    fon_reg   <= fon_c;
                    lat_reg   <= (feat_reg[0] ? 4'd0 : 4'd2) + lat;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        o_status_reg  <= status_reg;
                        state_reg     <= S_IDLE;
                        if (status_reg != ST_OK)
                        begin
                            o_rdiv_reg  <= '0;
                            o_mfb_reg   <= '0;
                            o_vfb_reg   <= '0;
                            o_vcode_reg <= '0;
                            o_gen_reg   <= '0;
                            o_ext_reg   <= '0;
                            o_cfg_reg   <= '0;
                            o_onoff_reg <= '0;
                        end
                        else
                        begin
                            o_rdiv_reg  <= rdiv_reg;
                            o_mfb_reg   <= mfb_reg;
                            o_vfb_reg   <= vfb_reg;
                            o_vcode_reg <= vcode_reg;
                            o_gen_reg   <= gen_c;
                            o_ext_reg   <= feat_reg[3] ? 5'd0 : {3'd0, mcode_reg};
                            if (feat_reg[1])
                            begin
                                o_cfg_reg   <= {prec_reg[2:0], lat_reg, 2'b00, xpr_sh[13:0]};
                                o_onoff_reg <= {foff_sh[10:0], 5'd0, fon_sh[10:0]};
                            end
                            else
                            begin
                                o_cfg_reg   <= '0;
                                o_onoff_reg <= '0;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid                   = out_valid_reg;
    assign rsp.status                  = o_status_reg;
    assign rsp.reference_divider       = o_rdiv_reg;
    assign rsp.memory_feedback_divider = o_mfb_reg;
    assign rsp.pixel_feedback_divider  = o_vfb_reg;
    assign rsp.pixel_post_code         = o_vcode_reg;
    assign rsp.general_control         = o_gen_reg;
    assign rsp.extended_control        = o_ext_reg;
    assign rsp.fifo_config_word        = o_cfg_reg;
    assign rsp.fifo_on_off_word        = o_onoff_reg;

    `PDFT_ASSERT_SAME(a_idle_div_free, state_reg == S_IDLE, !dstat.busy)
    `PDFT_ASSERT_SAME(a_done_in_wait, dstat.done,
        state_reg == S_DRDIV || state_reg == S_DMEM || state_reg == S_DPIX || state_reg == S_DXPR)
    `PDFT_ASSERT_SAME(a_err_zero, out_valid_reg && o_status_reg != ST_OK,
        o_rdiv_reg == '0 && o_cfg_reg == '0 && o_onoff_reg == '0 && o_gen_reg == '0)
    `PDFT_ASSERT_NEXT(a_done_result, state_reg == S_DONE && out_free, out_valid_reg)

endmodule
